@@ src/gbns_pkg.sv @@
package gbns_pkg;

	localparam int WINDOW_DEPTH_DEF  = 8;
	localparam int FIFO_DEPTH_DEF    = 64;
	localparam int MESSAGE_BYTES_DEF = 20;

	localparam int PAY_W = 160;
	localparam int SEQ_W = 31;
	localparam int SUM_W = 16;
	localparam int TMR_W = 16;

	localparam logic [1:0] REQ_MSG  = 2'd0;
	localparam logic [1:0] REQ_RX   = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic KIND_PKT  = 1'b0;
	localparam logic KIND_DROP = 1'b1;

	localparam logic       REG_TIMEOUT = 1'b0;
	localparam logic [TMR_W-1:0] TIMEOUT_RST = 16'd100;

	typedef struct packed {
		logic             kind;
		logic [SEQ_W-1:0] seq;
		logic [SUM_W-1:0] sum;
		logic [PAY_W-1:0] pay;
	} res_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SUM  = 7'b0000010,
		ST_POP  = 7'b0000100,
		ST_FLD  = 7'b0001000,
		ST_PUSH = 7'b0010000,
		ST_RTX  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

endpackage

@@ src/go_back_n_sender_core.sv @@
// Go-Back-N sender core.
// Input channel (in_valid/in_ready): one beat is a message (req_type 0), a packet from
// the receiver (1) or a timer tick (2). Output channel (out_valid/out_ready): one beat per
// packet to transmit or per overflow drop notice; last marks the final beat of an input.
// Config: APB write to byte address 0 sets timeout_ticks (reset value 100).
// One input is taken at a time; in_ready is high only while the sequencer is idle.
// The checksum is built by one shared 16-bit rotate-add unit, one word per cycle:
// 2 + ceil(MESSAGE_BYTES/2) words per packet (12 at 20 bytes).
// A new message sent at once passes the checksum, push and closing states before in_ready rises again.
// A received packet takes the checksum pass, one pop step per acked window slot,
// a fetch, checksum and push per packet refilled from the message FIFO (FIFO read is registered)
// and the closing state.
// A timer expiry resends the window through the RTX and PUSH states for each packet.
// Results pass through a one-deep hold stage (to know which beat is last) and an output
// register; when the receiver stalls, the sequencer waits and takes no new input.
// Reset empties window and FIFO, stops the timer and sets base and next sequence to 1.
// Window and FIFO storage are not cleared at reset; no clearing pass is needed.
module go_back_n_sender_core
	import gbns_pkg::*;
#(
	parameter int WINDOW_DEPTH  = WINDOW_DEPTH_DEF,
	parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF,
	parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  logic [63:0]      payload_w0,
	input  logic [63:0]      payload_w1,
	input  logic [31:0]      payload_w2,
	input  logic [SEQ_W-1:0] rx_seq,
	input  logic [SEQ_W-1:0] rx_ack,
	input  logic [SUM_W-1:0] rx_checksum,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_kind,
	output logic [SEQ_W-1:0] tx_seq,
	output logic [SEQ_W-1:0] tx_ack,
	output logic [SUM_W-1:0] tx_checksum,
	output logic [63:0]      tx_w0,
	output logic [63:0]      tx_w1,
	output logic [31:0]      tx_w2,
	output logic             last
);

	localparam int WIW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int EW    = WIW + 1;
	localparam int CW    = $clog2(WINDOW_DEPTH + 1);
	localparam int FAW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCW   = $clog2(FIFO_DEPTH + 1);
	localparam int NPAIR = (MESSAGE_BYTES + 1) / 2;
	localparam int NSTEP = 2 + NPAIR;
	localparam int KW    = $clog2(NSTEP);

	state_t state_q;

	logic [TMR_W-1:0] timeout_q;
	logic [SEQ_W-1:0] base_q, next_q;
	logic [WIW-1:0]   head_q;
	logic [CW-1:0]    cnt_q;
	logic [FAW-1:0]   frd_q, fwr_q;
	logic [FCW-1:0]   fcnt_q;
	logic             run_q;
	logic [TMR_W-1:0] left_q;
	logic [KW-1:0]    k_q;
	logic [CW-1:0]    i_q;
	logic             rx_mode_q, ackloop_q, rtx_q;
	logic             hold_v_q, out_v_q, out_last_q;

	logic [SEQ_W-1:0] wseq_q [WINDOW_DEPTH];
	logic [SUM_W-1:0] wsum_q [WINDOW_DEPTH];
	logic [PAY_W-1:0] wpay_q [WINDOW_DEPTH];
	logic [PAY_W-1:0] fmem [FIFO_DEPTH];
	logic [PAY_W-1:0] fifo_rdata_q;

	logic [PAY_W-1:0] pay_q;
	logic [SEQ_W-1:0] seqa_q, ack_q;
	logic [SUM_W-1:0] rxsum_q, sum_q;
	res_t             res_q, hold_q, out_res_q;

	logic [PAY_W-1:0] flat_in, cut;
	logic [SUM_W-1:0] op, s_next;
	logic [EW-1:0]    tail_sum, ridx_sum;
	logic [WIW-1:0]   tail, ridx, head_inc;
	logic             acc, msg_ok, win_room, ffull;
	logic             go_send, go_drop, go_queue, go_rx, tick, expire;
	logic             sum_done, send_done, chk_ok, pop_hit, pop_fifo, pop_end, rtx_emit;
	logic             out_free, push_go, fin_go, cfg_wr;
	logic [SEQ_W-1:0] ack_inc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'h0000, timeout_q} : 32'h0;

	assign flat_in = {payload_w0, payload_w1, payload_w2};

	// bytes survive up to the first zero byte and below the message length
	always_comb begin
		logic live;
		live = 1'b1;
		cut  = '0;
		for (int b = 0; b < PAY_W / 8; b++) begin
			if (b >= MESSAGE_BYTES || flat_in[PAY_W-1-8*b -: 8] == 8'h00)
				live = 1'b0;
			if (live)
				cut[PAY_W-1-8*b -: 8] = flat_in[PAY_W-1-8*b -: 8];
		end
	end

	// checksum operand for the current step
	always_comb begin
		op = '0;
		if (k_q == KW'(0)) begin
			op = seqa_q[SUM_W-1:0];
		end else if (k_q == KW'(1)) begin
			op = rx_mode_q ? ack_q[SUM_W-1:0] : seqa_q[SUM_W-1:0];
		end else begin
			for (int j = 0; j < NPAIR; j++) begin
				if (k_q == KW'(2 + j)) begin
					if (2 * j + 1 < MESSAGE_BYTES)
						op = pay_q[PAY_W-1-16*j -: 16];
					else
						op = {8'h00, pay_q[PAY_W-1-16*j -: 8]};
				end
			end
		end
	end
	assign s_next = SUM_W'({sum_q[0], sum_q[SUM_W-1:1]} + op);

	always_comb begin
		tail_sum = EW'(head_q) + EW'(cnt_q);
		if (tail_sum >= EW'(WINDOW_DEPTH))
			tail_sum = tail_sum - EW'(WINDOW_DEPTH);
		tail = tail_sum[WIW-1:0];
		ridx_sum = EW'(head_q) + EW'(i_q);
		if (ridx_sum >= EW'(WINDOW_DEPTH))
			ridx_sum = ridx_sum - EW'(WINDOW_DEPTH);
		ridx = ridx_sum[WIW-1:0];
		head_inc = (head_q == WIW'(WINDOW_DEPTH - 1)) ? '0 : head_q + WIW'(1);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign msg_ok   = (req_type == REQ_MSG) && (flat_in[PAY_W-1 -: 8] != 8'h00);
	assign win_room = (cnt_q < CW'(WINDOW_DEPTH));
	assign ffull    = (fcnt_q == FCW'(FIFO_DEPTH));
	assign go_send  = acc && msg_ok && win_room;
	assign go_drop  = acc && msg_ok && !win_room && ffull;
	assign go_queue = acc && msg_ok && !win_room && !ffull;
	assign go_rx    = acc && (req_type == REQ_RX);
	assign tick     = acc && (req_type == REQ_TICK) && run_q;
	assign expire   = tick && (left_q <= TMR_W'(1));

	assign sum_done  = (state_q == ST_SUM) && (k_q == KW'(NSTEP - 1));
	assign send_done = sum_done && !rx_mode_q;
	assign chk_ok    = sum_done && rx_mode_q && (s_next == rxsum_q) &&
		!(32'({1'b0, ack_q}) > 32'({1'b0, base_q}) + 32'(WINDOW_DEPTH));
	assign pop_hit   = (state_q == ST_POP) && (cnt_q != '0) && (wseq_q[head_q] <= ack_q);
	assign pop_fifo  = pop_hit && (fcnt_q != '0);
	assign pop_end   = (state_q == ST_POP) && !pop_hit;
	assign rtx_emit  = (state_q == ST_RTX) && (i_q < cnt_q);
	assign ack_inc   = ack_q + SEQ_W'(1);

	assign out_free = !out_v_q || out_ready;
	assign push_go  = (state_q == ST_PUSH) && (!hold_v_q || out_free);
	assign fin_go   = (state_q == ST_FIN) && (!hold_v_q || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			timeout_q  <= TIMEOUT_RST;
			base_q     <= SEQ_W'(1);
			next_q     <= SEQ_W'(1);
			head_q     <= '0;
			cnt_q      <= '0;
			frd_q      <= '0;
			fwr_q      <= '0;
			fcnt_q     <= '0;
			run_q      <= 1'b0;
			left_q     <= '0;
			k_q        <= '0;
			i_q        <= '0;
			rx_mode_q  <= 1'b0;
			ackloop_q  <= 1'b0;
			rtx_q      <= 1'b0;
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_wr)
				timeout_q <= pwdata[TMR_W-1:0];

			if (acc) begin
				rx_mode_q <= go_rx;
				ackloop_q <= 1'b0;
				rtx_q     <= expire;
				k_q       <= '0;
				i_q       <= '0;
			end
			if (state_q == ST_FLD) begin
				rx_mode_q <= 1'b0;
				k_q       <= '0;
			end
			if (state_q == ST_SUM && !sum_done)
				k_q <= k_q + KW'(1);
			if (chk_ok)
				ackloop_q <= 1'b1;
			if (rtx_emit)
				i_q <= i_q + CW'(1);

			if (go_queue) begin
				fwr_q  <= (fwr_q == FAW'(FIFO_DEPTH - 1)) ? '0 : fwr_q + FAW'(1);
				fcnt_q <= fcnt_q + FCW'(1);
			end
			if (pop_fifo) begin
				frd_q  <= (frd_q == FAW'(FIFO_DEPTH - 1)) ? '0 : frd_q + FAW'(1);
				fcnt_q <= fcnt_q - FCW'(1);
			end

			if (send_done) begin
				if (base_q == next_q) begin
					run_q  <= 1'b1;
					left_q <= timeout_q;
				end
				next_q <= next_q + SEQ_W'(1);
				cnt_q  <= cnt_q + CW'(1);
			end
			if (pop_hit) begin
				head_q <= head_inc;
				cnt_q  <= cnt_q - CW'(1);
			end
			if (pop_end) begin
				base_q <= ack_inc;
				if (ack_inc == next_q) begin
					run_q  <= 1'b0;
					left_q <= '0;
				end else begin
					run_q  <= 1'b1;
					left_q <= timeout_q;
				end
			end
			if (tick) begin
				if (expire)
					left_q <= timeout_q;
				else
					left_q <= left_q - TMR_W'(1);
			end

			// one result is held back until we know whether it is the last beat
			if ((push_go || fin_go) && hold_v_q) begin
				out_v_q    <= 1'b1;
				out_last_q <= (state_q == ST_FIN);
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (push_go)
				hold_v_q <= 1'b1;
			else if (fin_go)
				hold_v_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (go_send || go_rx)
						state_q <= ST_SUM;
					else if (go_drop)
						state_q <= ST_PUSH;
					else if (expire && cnt_q != '0)
						state_q <= ST_RTX;
				end
				ST_SUM: begin
					if (sum_done) begin
						if (!rx_mode_q)
							state_q <= ST_PUSH;
						else if (chk_ok)
							state_q <= ST_POP;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					if (pop_fifo)
						state_q <= ST_FLD;
					else if (pop_end)
						state_q <= ST_FIN;
				end
				ST_FLD: state_q <= ST_SUM;
				ST_PUSH: begin
					if (push_go) begin
						if (ackloop_q)
							state_q <= ST_POP;
						else if (rtx_q)
							state_q <= ST_RTX;
						else
							state_q <= ST_FIN;
					end
				end
				ST_RTX: state_q <= rtx_emit ? ST_PUSH : ST_FIN;
				ST_FIN: begin
					if (fin_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		fifo_rdata_q <= fmem[frd_q];
		if (go_queue)
			fmem[fwr_q] <= cut;

		if (go_send || go_rx) begin
			pay_q   <= go_send ? cut : flat_in;
			seqa_q  <= go_rx ? rx_seq : next_q;
			ack_q   <= rx_ack;
			rxsum_q <= rx_checksum;
			sum_q   <= '0;
		end
		if (state_q == ST_FLD) begin
			pay_q  <= fifo_rdata_q;
			seqa_q <= next_q;
			sum_q  <= '0;
		end
		if (state_q == ST_SUM)
			sum_q <= s_next;

		if (go_drop)
			res_q <= '{kind: KIND_DROP, seq: '0, sum: '0, pay: '0};
		if (send_done) begin
			wseq_q[tail] <= seqa_q;
			wsum_q[tail] <= s_next;
			wpay_q[tail] <= pay_q;
			res_q <= '{kind: KIND_PKT, seq: seqa_q, sum: s_next, pay: pay_q};
		end
		if (rtx_emit)
			res_q <= '{kind: KIND_PKT, seq: wseq_q[ridx], sum: wsum_q[ridx], pay: wpay_q[ridx]};

		if (push_go)
			hold_q <= res_q;
		if ((push_go || fin_go) && hold_v_q)
			out_res_q <= hold_q;
	end

	assign out_valid   = out_v_q;
	assign out_kind    = out_res_q.kind;
	assign tx_seq      = out_res_q.seq;
	assign tx_ack      = out_res_q.seq;
	assign tx_checksum = out_res_q.sum;
	assign tx_w0       = out_res_q.pay[PAY_W-1 -: 64];
	assign tx_w1       = out_res_q.pay[95:32];
	assign tx_w2       = out_res_q.pay[31:0];
	assign last        = out_last_q;

	a_win_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WINDOW_DEPTH))
		else $error("window count above depth");

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FCW'(FIFO_DEPTH))
		else $error("fifo count above depth");

	a_timer_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (left_q == '0))
		else $error("stopped timer holds a count");

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_v_q)
		else $error("result left in hold stage while idle");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import gbns_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int WIN = 8;
	localparam int FDEPTH = 64;
	localparam int NBYTES = 20;

	typedef struct packed {
		logic             kind;
		logic [SEQ_W-1:0] seq;
		logic [SUM_W-1:0] sum;
		logic [PAY_W-1:0] pay;
		logic             last;
	} tx_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = REQ_TICK;
	logic [63:0] payload_w0 = '0, payload_w1 = '0;
	logic [31:0] payload_w2 = '0;
	logic [SEQ_W-1:0] rx_seq = '0, rx_ack = '0;
	logic [SUM_W-1:0] rx_checksum = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic out_kind, last;
	logic [SEQ_W-1:0] tx_seq, tx_ack;
	logic [SUM_W-1:0] tx_checksum;
	logic [63:0] tx_w0, tx_w1;
	logic [31:0] tx_w2;

	go_back_n_sender_core i_dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// sender model state
	logic [SEQ_W-1:0] send_base, next_seq;
	int win_cnt;
	logic [SEQ_W-1:0] win_seq [WIN];
	logic [SUM_W-1:0] win_sum [WIN];
	logic [PAY_W-1:0] win_pay [WIN];
	logic [PAY_W-1:0] msg_fifo [$];
	bit timer_on;
	int timer_left;
	int timeout_ticks;

	tx_beat_t tx_expected [$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	function automatic logic [SUM_W-1:0] rot_add_sum(logic [SEQ_W-1:0] seq,
		logic [SEQ_W-1:0] ack, logic [PAY_W-1:0] pay);
		logic [SUM_W-1:0] s;
		s = '0;
		s = {s[0], s[15:1]} + seq[15:0];
		s = {s[0], s[15:1]} + ack[15:0];
		for (int i = 0; i < NBYTES; i += 2)
			s = {s[0], s[15:1]} + pay[PAY_W-1-8*i -: 16];
		return s;
	endfunction

	function automatic logic [PAY_W-1:0] cut_message(logic [PAY_W-1:0] raw);
		logic [PAY_W-1:0] p;
		bit live;
		p = '0;
		live = 1;
		for (int k = 0; k < NBYTES; k++) begin
			if (raw[PAY_W-1-8*k -: 8] == 8'd0)
				live = 0;
			if (live)
				p[PAY_W-1-8*k -: 8] = raw[PAY_W-1-8*k -: 8];
		end
		return p;
	endfunction

	task automatic push_beat(logic kind, logic [SEQ_W-1:0] seq, logic [SUM_W-1:0] sum,
		logic [PAY_W-1:0] pay);
		tx_beat_t b;
		b = '{kind, seq, sum, pay, 1'b0};
		tx_expected.push_back(b);
	endtask

	task automatic send_new_packet(logic [PAY_W-1:0] pay);
		logic [SUM_W-1:0] s;
		if (win_cnt < WIN) begin
			s = rot_add_sum(next_seq, next_seq, pay);
			win_seq[win_cnt] = next_seq;
			win_sum[win_cnt] = s;
			win_pay[win_cnt] = pay;
			push_beat(KIND_PKT, next_seq, s, pay);
			if (send_base == next_seq) begin
				timer_on = 1;
				timer_left = timeout_ticks;
			end
			next_seq = next_seq + 1'b1;
			win_cnt++;
		end
	endtask

	task automatic predict(logic [1:0] req, logic [PAY_W-1:0] raw, logic [SEQ_W-1:0] rs,
		logic [SEQ_W-1:0] ra, logic [SUM_W-1:0] rsum);
		int n0;
		tx_beat_t b;
		n0 = tx_expected.size();
		if (req == REQ_MSG) begin
			if (raw[PAY_W-1 -: 8] != 8'd0) begin
				if (win_cnt < WIN)
					send_new_packet(cut_message(raw));
				else if (msg_fifo.size() >= FDEPTH)
					push_beat(KIND_DROP, '0, '0, '0);
				else
					msg_fifo.push_back(cut_message(raw));
			end
		end else if (req == REQ_RX) begin
			if (rsum == rot_add_sum(rs, ra, raw) && {1'b0, ra} <= {1'b0, send_base} + WIN) begin
				while (win_cnt > 0 && win_seq[0] <= ra) begin
					for (int i = 0; i < WIN - 1; i++) begin
						win_seq[i] = win_seq[i+1];
						win_sum[i] = win_sum[i+1];
						win_pay[i] = win_pay[i+1];
					end
					win_cnt--;
					if (msg_fifo.size() > 0)
						send_new_packet(msg_fifo.pop_front());
				end
				send_base = ra + 1'b1;
				if (send_base == next_seq) begin
					timer_on = 0;
					timer_left = 0;
				end else begin
					timer_on = 1;
					timer_left = timeout_ticks;
				end
			end
		end else if (req == REQ_TICK && timer_on) begin
			if (timer_left <= 1) begin
				timer_left = timeout_ticks;
				for (int i = 0; i < win_cnt; i++)
					push_beat(KIND_PKT, win_seq[i], win_sum[i], win_pay[i]);
			end else begin
				timer_left--;
			end
		end
		if (tx_expected.size() > n0) begin
			b = tx_expected.pop_back();
			b.last = 1'b1;
			tx_expected.push_back(b);
		end
	endtask

	// called at a falling edge; returns at a falling edge
	task automatic send_item(logic [1:0] req, logic [PAY_W-1:0] raw, logic [SEQ_W-1:0] rs,
		logic [SEQ_W-1:0] ra, logic [SUM_W-1:0] rsum);
		req_type = req;
		{payload_w0, payload_w1, payload_w2} = raw;
		rx_seq = rs;
		rx_ack = ra;
		rx_checksum = rsum;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict(req, raw, rs, ra, rsum);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
	endtask

	task automatic send_msg(logic [PAY_W-1:0] raw);
		send_item(REQ_MSG, raw, SEQ_W'($urandom), SEQ_W'($urandom), SUM_W'($urandom));
	endtask

	task automatic send_rx(logic [SEQ_W-1:0] ra, bit good);
		logic [PAY_W-1:0] raw;
		logic [SEQ_W-1:0] rs;
		logic [SUM_W-1:0] s;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		rs = SEQ_W'($urandom);
		s = rot_add_sum(rs, ra, raw);
		if (!good)
			s = s ^ SUM_W'($urandom_range(65535, 1));
		send_item(REQ_RX, raw, rs, ra, s);
	endtask

	task automatic send_tick();
		send_item(REQ_TICK, {$urandom, $urandom, $urandom, $urandom, $urandom},
			SEQ_W'($urandom), SEQ_W'($urandom), SUM_W'($urandom));
	endtask

	function automatic logic [PAY_W-1:0] rand_message();
		logic [PAY_W-1:0] p;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(9) == 0)
			p[PAY_W-1 -: 8] = 8'd0;
		if ($urandom_range(2) == 0)
			p[PAY_W-1-8*$urandom_range(NBYTES-1, 1) -: 8] = 8'd0;
		return p;
	endfunction

	// wait out all results plus the tail of any silent item
	task automatic drain();
		in_valid = 1'b0;
		while (tx_expected.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_timeout(logic [TMR_W-1:0] v);
		paddr = 3'(REG_TIMEOUT) << 2;
		pwdata = 32'(v);
		pwrite = 1'b1;
		psel = 1'b1;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		timeout_ticks = (v == 0) ? 1 : int'(v);
	endtask

	task automatic test_directed();
		write_timeout(16'd2);
		send_msg({PAY_W{1'b1}});
		send_msg({8'h00, {(PAY_W-8){1'b1}}});                 // empty message
		send_msg({8'h01, 8'h80, 8'h00, {(PAY_W-24){1'b1}}});   // cut at a zero byte
		send_msg({8'hff, {(PAY_W-16){1'b0}}, 8'hff});
		send_item(REQ_NONE, {PAY_W{1'b1}}, '1, '1, '1);
		send_tick();
		send_tick();                                            // expiry resends window
		send_rx(send_base + 9, 1'b1);                           // beyond the window
		send_rx(send_base, 1'b0);                               // bad checksum
		send_rx(send_base, 1'b1);
		send_rx(send_base - 2, 1'b1);                           // backward ack
		send_rx('1, 1'b0);
		send_rx(next_seq - 1, 1'b1);
		send_tick();
		send_tick();                                            // timer stopped
		drain();
	endtask

	task automatic test_overflow();
		write_timeout(16'hffff);
		repeat (WIN + FDEPTH + 3) send_msg(rand_message() | {8'h01, {(PAY_W-8){1'b0}}});
		while (win_cnt > 0) send_rx(send_base - 1 + SEQ_W'(win_cnt), 1'b1);
		drain();
	endtask

	task automatic test_random(int items, int idle, int stall, logic [TMR_W-1:0] tmo);
		int r;
		write_timeout(tmo);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(99);
			if (r < 38)
				send_msg(rand_message());
			else if (r < 65)
				send_rx(send_base - 1 + SEQ_W'($urandom_range(win_cnt)), 1'b1);
			else if (r < 72)
				send_rx(SEQ_W'($urandom), $urandom_range(1));
			else if (r < 74)
				send_item(REQ_NONE, {$urandom, $urandom, $urandom, $urandom, $urandom},
					SEQ_W'($urandom), SEQ_W'($urandom), SUM_W'($urandom));
			else
				send_tick();
		end
		drain();
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	task automatic check_field(string name, logic [PAY_W-1:0] exp_v, logic [PAY_W-1:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		tx_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (tx_expected.size() == 0) begin
				errors++;
				$display("%0t unexpected beat seq %h", $time, tx_seq);
			end else begin
				e = tx_expected.pop_front();
				check_field("out_kind", PAY_W'(e.kind), PAY_W'(out_kind));
				check_field("tx_seq", PAY_W'(e.seq), PAY_W'(tx_seq));
				check_field("tx_ack", PAY_W'(e.seq), PAY_W'(tx_ack));
				check_field("tx_checksum", PAY_W'(e.sum), PAY_W'(tx_checksum));
				check_field("tx_w0", PAY_W'(e.pay[159:96]), PAY_W'(tx_w0));
				check_field("tx_w1", PAY_W'(e.pay[95:32]), PAY_W'(tx_w1));
				check_field("tx_w2", PAY_W'(e.pay[31:0]), PAY_W'(tx_w2));
				check_field("last", PAY_W'(e.last), PAY_W'(last));
			end
		end
	end

	initial begin
		send_base = 1;
		next_seq = 1;
		win_cnt = 0;
		timer_on = 0;
		timer_left = 0;
		timeout_ticks = 100;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_overflow();
		test_random(85, 0, 0, 16'd3);
		test_random(85, 54, 0, 16'd1);
		test_random(85, 0, 54, 16'd0);
		test_random(85, 20, 20, 16'd2);
		test_random(30, 0, 0, 16'd100);
		if (errors == 0)
			$display("go_back_n_sender_core: match");
		else
			$display("go_back_n_sender_core: mismatch");
		$finish;
	end

	initial begin
		#5ms;
		$display("go_back_n_sender_core: mismatch");
		$finish;
	end

endmodule
